// ===== src/salwc_pkg.sv =====
// shared types, constants and helpers for the set-associative lru write-back cache
package salwc_pkg;

    localparam int MAX_WAYS = 8;
    localparam int WAY_W    = 3;
    localparam int MAX_SETS = 256;
    localparam int SET_W    = 8;
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 48;
    localparam int NUM_EV   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } t_cfg_idx;

    // event counter indexes
    typedef enum logic [2:0] {
        EV_ACC    = 3'd0,
        EV_HIT    = 3'd1,
        EV_MISS   = 3'd2,
        EV_WB     = 3'd3,
        EV_RD     = 3'd4,
        EV_WR     = 3'd5,
        EV_RDMISS = 3'd6,
        EV_WRMISS = 3'd7
    } t_event;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // event pulses, first counter in the low bit
    typedef struct packed {
        logic wrmiss;
        logic rdmiss;
        logic wr;
        logic rd;
        logic wb;
        logic miss;
        logic hit;
        logic acc;
    } t_events;

    typedef logic [NUM_EV-1:0][CNT_W-1:0] t_counts;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic             writeback;
        logic [CNT_W-1:0] access_count;
        logic [CNT_W-1:0] hit_count;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] writeback_count;
        logic [CNT_W-1:0] read_count;
        logic [CNT_W-1:0] write_count;
        logic [CNT_W-1:0] read_miss_count;
        logic [CNT_W-1:0] write_miss_count;
    } t_out_item;

    // per-set state: valid, dirty and lru rank of every way
    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0]            dirty;
        logic [MAX_WAYS-1:0][WAY_W-1:0] rank;
    } t_meta;

    // state of a set never written since reset
    function automatic t_meta meta_reset();
        t_meta m;
        m.valid = '0;
        m.dirty = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            m.rank[w] = WAY_W'(w);
        end
        return m;
    endfunction

endpackage

// ===== src/set_assoc_lru_writeback_cache_top.sv =====
// top level: tag-only set-associative write-back cache with true lru replacement
// sequence: read, scan and update states, then the result strobe; the scan compares 1 to ways in use ways;
// the tag compare walks the ways one per cycle through a single comparator and tag port.
// a new item is accepted only while idle; busy stays high until the set update is written.
// reset: synchronous active low; registers return to 6/8/4, counters clear, per-set
// row flags clear so every set reads as empty with rank equal to way number.
module set_assoc_lru_writeback_cache_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  salwc_pkg::t_in_item                 i_item,
    output logic                                o_result_valid,
    output salwc_pkg::t_out_item                o_result,
    input  logic                                i_cfg_we,
    input  logic [salwc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [salwc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import salwc_pkg::*;

    // configuration
    logic [4:0] r_offset_bits;
    logic [3:0] r_index_bits;
    logic [3:0] r_ways_in_use;

    // sequencer
    t_state r_state, n_state;

    // item registers
    logic [SET_W-1:0]  r_set;
    logic [ADDR_W-1:0] r_tag;
    logic              r_wr;
    logic [WAY_W-1:0]  r_way;

    // scan results
    logic             r_hit;
    logic [WAY_W-1:0] r_hit_way;
    logic             r_inv_found;
    logic [WAY_W-1:0] r_inv_way;
    logic [WAY_W-1:0] r_vic_way;
    logic [WAY_W-1:0] r_vic_rank;

    // memories
    logic [ADDR_W-1:0]       tag_mem [MAX_SETS*MAX_WAYS];
    t_meta                   meta_mem [MAX_SETS];
    logic [MAX_SETS-1:0]     r_row_ok;
    logic [ADDR_W-1:0]       r_tag_rd;
    t_meta                   r_meta_rd;
    logic                    r_meta_ok;

    // result
    logic    r_out_valid;
    logic    r_out_hit;
    logic    r_out_wb;
    t_events ev;
    t_counts cnt;

    // combinational helpers
    logic [3:0]           ib;
    logic [3:0]           ways;
    logic [WAY_W-1:0]     ways_m1;
    logic [63:0]          addr_ext;
    logic [63:0]          set_full;
    logic [63:0]          tag_full;
    logic [8:0]           set_mask;
    logic [SET_W-1:0]     in_set;
    logic [SET_W+WAY_W-1:0] tag_rd_addr;
    t_meta                meta;
    logic                 way_match;
    logic                 scan_last;
    logic [WAY_W-1:0]     upd_way;
    logic                 upd_wb;
    logic [WAY_W-1:0]     old_rank;
    t_meta                meta_new;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 5'd6;
            r_index_bits  <= 4'd8;
            r_ways_in_use <= 4'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[3:0];
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clamp index width and way count
    assign ib      = (r_index_bits > 4'(SET_W)) ? 4'(SET_W) : r_index_bits;
    assign ways    = (r_ways_in_use == 4'd0) ? 4'd1 :
                     (r_ways_in_use > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : r_ways_in_use;
    assign ways_m1 = WAY_W'(ways - 4'd1);

    // address split
    assign addr_ext = {32'd0, i_item.address};
    assign set_full = addr_ext >> r_offset_bits;
    assign tag_full = addr_ext >> (6'(r_offset_bits) + 6'(ib));
    assign set_mask = (9'd1 << ib) - 9'd1;
    assign in_set   = set_full[SET_W-1:0] & set_mask[SET_W-1:0];

    // set state as read, empty if never written
    assign meta = r_meta_ok ? r_meta_rd : meta_reset();

    // one way compared per scan cycle
    assign way_match = meta.valid[r_way] && (r_tag_rd == r_tag);
    assign scan_last = way_match || (r_way == ways_m1);

    // tag memory read address: way 0 on entry, then the next way
    always_comb begin
        if (r_state == ST_READ) begin
            tag_rd_addr = {r_set, {WAY_W{1'b0}}};
        end else begin
            tag_rd_addr = {r_set, WAY_W'(r_way + WAY_W'(1))};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_READ;
            ST_READ:   n_state = ST_SCAN;
            ST_SCAN:   if (scan_last) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the item on accept
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_set <= in_set;
            r_tag <= tag_full[ADDR_W-1:0];
            r_wr  <= i_item.is_write;
        end
    end

    // memory reads
    always_ff @(posedge i_clk) begin
        r_tag_rd <= tag_mem[tag_rd_addr];
        if (r_state == ST_READ) begin
            r_meta_rd <= meta_mem[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_meta_ok <= r_row_ok[r_set];
        end
    end

    // way scan: hit, first invalid way, highest rank
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_way <= WAY_W'(r_way + WAY_W'(1));
            if (way_match) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_way;
            end
            if (!meta.valid[r_way] && !r_inv_found) begin
                r_inv_found <= 1'b1;
                r_inv_way   <= r_way;
            end
            if (r_way == '0 || meta.rank[r_way] > r_vic_rank) begin
                r_vic_way  <= r_way;
                r_vic_rank <= meta.rank[r_way];
            end
        end
    end

    // chosen way and new set state
    assign upd_way  = r_hit ? r_hit_way : (r_inv_found ? r_inv_way : r_vic_way);
    assign upd_wb   = !r_hit && !r_inv_found && meta.dirty[upd_way];
    assign old_rank = meta.rank[upd_way];

    always_comb begin
        meta_new = meta;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (meta.rank[w] < old_rank) begin
                meta_new.rank[w] = WAY_W'(meta.rank[w] + WAY_W'(1));
            end
        end
        meta_new.rank[upd_way]  = '0;
        meta_new.valid[upd_way] = 1'b1;
        meta_new.dirty[upd_way] = r_hit ? (meta.dirty[upd_way] | r_wr) : r_wr;
    end

    // write back set state and fill tag
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            meta_mem[r_set] <= meta_new;
            if (!r_hit) begin
                tag_mem[{r_set, upd_way}] <= r_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (r_state == ST_UPDATE) begin
            r_row_ok[r_set] <= 1'b1;
        end
    end

    // event pulses
    always_comb begin
        ev        = '0;
        if (r_state == ST_UPDATE) begin
            ev.acc    = 1'b1;
            ev.rd     = !r_wr;
            ev.wr     = r_wr;
            ev.hit    = r_hit;
            ev.miss   = !r_hit;
            ev.rdmiss = !r_hit && !r_wr;
            ev.wrmiss = !r_hit && r_wr;
            ev.wb     = upd_wb;
        end
    end

    salwc_counters u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (ev),
        .o_cnt   (cnt)
    );

    // result strobe, registered in the cycle after the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == ST_UPDATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_out_hit <= r_hit;
            r_out_wb  <= upd_wb;
        end
    end

    assign o_result_valid            = r_out_valid;
    assign o_result.hit              = r_out_hit;
    assign o_result.writeback        = r_out_wb;
    assign o_result.access_count     = cnt[EV_ACC];
    assign o_result.hit_count        = cnt[EV_HIT];
    assign o_result.miss_count       = cnt[EV_MISS];
    assign o_result.writeback_count  = cnt[EV_WB];
    assign o_result.read_count       = cnt[EV_RD];
    assign o_result.write_count      = cnt[EV_WR];
    assign o_result.read_miss_count  = cnt[EV_RDMISS];
    assign o_result.write_miss_count = cnt[EV_WRMISS];

endmodule

// ===== src/salwc_counters.sv =====
// eight saturating 48-bit event counters
module salwc_counters (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  salwc_pkg::t_events i_ev,
    output salwc_pkg::t_counts o_cnt
);
    import salwc_pkg::*;

    logic [NUM_EV-1:0] ev_vec;
    t_counts           r_cnt;

    assign ev_vec = i_ev;
    assign o_cnt  = r_cnt;

    // count each event, holding at all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            for (int k = 0; k < NUM_EV; k++) begin
                if (ev_vec[k] && (r_cnt[k] != {CNT_W{1'b1}})) begin
                    r_cnt[k] <= r_cnt[k] + CNT_W'(1);
                end
            end
        end
    end

endmodule
